// ===== src/wcus_pkg.sv =====
// shared types and constants of the windowed conservative-update sketch
`timescale 1ns / 1ps

package wcus_pkg;

    localparam int CNT_W   = 31;
    localparam int WIN_W   = 16;
    localparam int IDX_W   = 10;
    localparam int CELL_W  = 15;
    localparam int MODE_W  = 2;
    localparam int LB_W    = 16;
    localparam int TAG_W   = 16;

    localparam int INDEX_INPUTS = 4;
    // compare-subtract steps that bring a 10-bit index below any width of 16 or more
    localparam int RED_STEPS = 6;

    localparam logic [CELL_W-1:0] CELL_MAX  = 15'h7FFF;
    localparam logic [WIN_W-1:0]  WIN_RESET = 16'd1024;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quot;
        logic [WIN_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== src/windowed_conservative_update_sketch.sv =====
// top level of the windowed conservative-update sketch
// Sliding-window conservative-update count-min sketch over pre-hashed column indices. All
// counters live in one memory with one read and one write port. An insert checks the tag
// of its area, clears that area first when it is stale, then reads each row and writes
// back the rows at the minimum; a query reads every area of every row; a clear or an
// unused mode goes straight to completion. After reset the block clears the whole memory,
// one address per cycle, with s_ready low. A write of the window length register runs one
// pass of a bit-serial divider, and s_ready stays low from the write cycle until the
// divider result has been taken. A finished result waits in the output register.
`timescale 1ns / 1ps

module windowed_conservative_update_sketch #(
    parameter int ROWS  = 4,
    parameter int WIDTH = 1024,
    parameter int AREAS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wcus_pkg::WIN_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wcus_pkg::MODE_W-1:0]    s_mode,
    input  logic [wcus_pkg::IDX_W-1:0]     s_row0_index,
    input  logic [wcus_pkg::IDX_W-1:0]     s_row1_index,
    input  logic [wcus_pkg::IDX_W-1:0]     s_row2_index,
    input  logic [wcus_pkg::IDX_W-1:0]     s_row3_index,
    input  logic [wcus_pkg::LB_W-1:0]      s_lookback,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wcus_pkg::CNT_W-1:0]     m_value
);

    localparam int COLW   = $clog2(WIDTH);
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW     = $clog2(AREAS);
    localparam int ADDR_W = AW + RW + COLW;
    localparam int SUMW   = wcus_pkg::CELL_W + AW;
    localparam int RED_W  = 23;

    localparam int AREA_SH = wcus_pkg::TAG_W + AW;
    localparam int PROD_W  = 2 * wcus_pkg::TAG_W + 4;
    localparam logic [PROD_W-1:0] AREA_MUL =
        PROD_W'(((64'd1 << AREA_SH) + 64'(AREAS) - 64'd1) / 64'(AREAS));

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DIVQ = 4'd2;
    localparam logic [3:0] ST_DIVA = 4'd3;
    localparam logic [3:0] ST_ITAG = 4'd4;
    localparam logic [3:0] ST_ACLR = 4'd5;
    localparam logic [3:0] ST_IRD  = 4'd6;
    localparam logic [3:0] ST_IWR  = 4'd7;
    localparam logic [3:0] ST_QRD  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    function automatic logic [COLW-1:0] reduce_col(input logic [wcus_pkg::IDX_W-1:0] idx);
        logic [RED_W-1:0] v;
        logic [RED_W-1:0] thr;
        v = RED_W'(idx);
        for (int k = wcus_pkg::RED_STEPS - 1; k >= 0; k--) begin
            thr = RED_W'(WIDTH) << k;
            if (v >= thr) begin
                v = v - thr;
            end
        end
        return v[COLW-1:0];
    endfunction

    logic [3:0]                    state_reg, state_next;
    logic [wcus_pkg::WIN_W-1:0]    window_reg, window_next;
    logic                          pend_reg, pend_next;
    logic [wcus_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [wcus_pkg::CNT_W-1:0]    epoch_reg, epoch_next;
    logic [wcus_pkg::WIN_W-1:0]    rem_reg, rem_next;
    logic [AW-1:0]                 area_reg, area_next;
    logic [wcus_pkg::TAG_W-1:0]    tag_reg [AREAS];
    logic [wcus_pkg::TAG_W-1:0]    tag_next [AREAS];
    logic [ADDR_W-1:0]             init_addr_reg, init_addr_next;
    logic                          iss_done_reg, iss_done_next;
    logic                          d_vld_reg, d_vld_next;
    logic                          m_valid_reg, m_valid_next;

    logic [wcus_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [COLW-1:0]               col_reg [ROWS];
    logic [COLW-1:0]               col_next [ROWS];
    logic [wcus_pkg::LB_W-1:0]     lb_reg, lb_next;
    logic [RW-1:0]                 ir_reg, ir_next;
    logic [AW-1:0]                 ia_reg, ia_next;
    logic [COLW-1:0]               clr_col_reg, clr_col_next;
    logic [RW-1:0]                 d_row_reg, d_row_next;
    logic [AW-1:0]                 d_area_reg, d_area_next;
    logic                          d_last_reg, d_last_next;
    logic [wcus_pkg::CELL_W-1:0]   cell_reg [ROWS];
    logic [wcus_pkg::CELL_W-1:0]   cell_next [ROWS];
    logic [wcus_pkg::CELL_W-1:0]   min_reg, min_next;
    logic [SUMW-1:0]               sum_reg, sum_next;
    logic [SUMW-1:0]               best_reg, best_next;
    logic [wcus_pkg::CNT_W-1:0]    res_reg, res_next;
    logic [wcus_pkg::CNT_W-1:0]    m_value_reg, m_value_next;

    logic [wcus_pkg::WIN_W-1:0]    w_eff;
    logic [wcus_pkg::CNT_W-1:0]    count_inc;
    logic [wcus_pkg::IDX_W-1:0]    idx_in [ROWS];
    logic [AREAS-1:0]              tag_ok;
    logic [SUMW-1:0]               row_sum;
    logic [SUMW-1:0]               best_cand;
    logic [PROD_W-1:0]             area_prod;
    logic [wcus_pkg::TAG_W-1:0]    area_quo;
    logic [wcus_pkg::TAG_W-1:0]    area_rem;

    wcus_pkg::div_req_t            div_req;
    wcus_pkg::div_rsp_t            div_rsp;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [wcus_pkg::CELL_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [wcus_pkg::CELL_W-1:0]   mem_rdata;

    wcus_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    wcus_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign w_eff     = (window_reg == '0) ? wcus_pkg::WIN_W'(1) : window_reg;
    assign count_inc = (&count_reg) ? '0 : count_reg + 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !pend_reg && !cfg_wr_en;
    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;

    // low TAG_W bits of epoch mod AREAS by reciprocal multiplication
    assign area_prod = PROD_W'(epoch_reg[wcus_pkg::TAG_W-1:0]) * AREA_MUL;
    assign area_quo  = area_prod[AREA_SH +: wcus_pkg::TAG_W];
    assign area_rem  = epoch_reg[wcus_pkg::TAG_W-1:0]
                       - wcus_pkg::TAG_W'(area_quo * wcus_pkg::TAG_W'(AREAS));

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            idx_in[r] = '0;
            if (r == 0) begin
                idx_in[r] = s_row0_index;
            end else if (r == 1) begin
                idx_in[r] = s_row1_index;
            end else if (r == 2) begin
                idx_in[r] = s_row2_index;
            end else if (r == 3) begin
                idx_in[r] = s_row3_index;
            end
        end
        // tag >= epoch - lookback, rearranged to stay unsigned
        for (int a = 0; a < AREAS; a++) begin
            tag_ok[a] = (wcus_pkg::CNT_W'({1'b0, tag_reg[a]} + {1'b0, lb_reg}) >= epoch_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        window_next    = window_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        epoch_next     = epoch_reg;
        rem_next       = rem_reg;
        area_next      = area_reg;
        tag_next       = tag_reg;
        init_addr_next = init_addr_reg;
        iss_done_next  = iss_done_reg;
        d_vld_next     = d_vld_reg;
        m_valid_next   = m_valid_reg;
        mode_next      = mode_reg;
        col_next       = col_reg;
        lb_next        = lb_reg;
        ir_next        = ir_reg;
        ia_next        = ia_reg;
        clr_col_next   = clr_col_reg;
        d_row_next     = d_row_reg;
        d_area_next    = d_area_reg;
        d_last_next    = d_last_reg;
        cell_next      = cell_reg;
        min_next       = min_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        m_value_next   = m_value_reg;
        row_sum        = '0;
        best_cand      = best_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        div_req.start    = 1'b0;
        div_req.dividend = count_reg;
        div_req.divisor  = w_eff;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                mem_we         = 1'b1;
                mem_waddr      = init_addr_reg;
                init_addr_next = init_addr_reg + 1'b1;
                if (&init_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pend_reg) begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_DIVQ;
                end else if (s_valid && s_ready) begin
                    mode_next     = s_mode;
                    lb_next       = s_lookback;
                    for (int r = 0; r < ROWS; r++) begin
                        col_next[r] = reduce_col(idx_in[r]);
                    end
                    ir_next       = '0;
                    ia_next       = '0;
                    iss_done_next = 1'b0;
                    d_vld_next    = 1'b0;
                    min_next      = wcus_pkg::CELL_MAX;
                    sum_next      = '0;
                    best_next     = '1;
                    res_next      = '0;
                    if (s_mode == wcus_pkg::MODE_INSERT) begin
                        state_next = ST_ITAG;
                    end else if (s_mode == wcus_pkg::MODE_QUERY) begin
                        state_next = ST_QRD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIVQ: begin
                if (div_rsp.done) begin
                    epoch_next = div_rsp.quot;
                    rem_next   = div_rsp.rem;
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA: begin
                area_next  = area_rem[AW-1:0];
                state_next = ST_IDLE;
            end
            ST_ITAG: begin
                if (tag_reg[area_reg] != epoch_reg[wcus_pkg::TAG_W-1:0]) begin
                    tag_next[area_reg] = epoch_reg[wcus_pkg::TAG_W-1:0];
                    ir_next            = '0;
                    clr_col_next       = '0;
                    state_next         = ST_ACLR;
                end else begin
                    state_next = ST_IRD;
                end
            end
            ST_ACLR: begin
                mem_we    = 1'b1;
                mem_waddr = {area_reg, ir_reg, clr_col_reg};
                if (clr_col_reg == COLW'(WIDTH - 1)) begin
                    clr_col_next = '0;
                    if (ir_reg == RW'(ROWS - 1)) begin
                        ir_next    = '0;
                        state_next = ST_IRD;
                    end else begin
                        ir_next = ir_reg + 1'b1;
                    end
                end else begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end
            ST_IRD: begin
                if (!iss_done_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = {area_reg, ir_reg, col_reg[ir_reg]};
                    d_vld_next = 1'b1;
                    d_row_next = ir_reg;
                    if (ir_reg == RW'(ROWS - 1)) begin
                        iss_done_next = 1'b1;
                        ir_next       = '0;
                    end else begin
                        ir_next = ir_reg + 1'b1;
                    end
                end else begin
                    d_vld_next = 1'b0;
                end
                if (d_vld_reg) begin
                    cell_next[d_row_reg] = mem_rdata;
                    if (mem_rdata < min_reg) begin
                        min_next = mem_rdata;
                    end
                    if (d_row_reg == RW'(ROWS - 1)) begin
                        state_next = ST_IWR;
                    end
                end
            end
            ST_IWR: begin
                // conservative update: only the counters at the minimum move
                if (cell_reg[ir_reg] == min_reg && min_reg != wcus_pkg::CELL_MAX) begin
                    mem_we    = 1'b1;
                    mem_waddr = {area_reg, ir_reg, col_reg[ir_reg]};
                    mem_wdata = min_reg + 1'b1;
                end
                if (ir_reg == RW'(ROWS - 1)) begin
                    ir_next    = '0;
                    res_next   = count_inc;
                    state_next = ST_DONE;
                end else begin
                    ir_next = ir_reg + 1'b1;
                end
            end
            ST_QRD: begin
                if (!iss_done_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = {ia_reg, ir_reg, col_reg[ir_reg]};
                    d_vld_next  = 1'b1;
                    d_area_next = ia_reg;
                    d_last_next = (ia_reg == AW'(AREAS - 1)) && (ir_reg == RW'(ROWS - 1));
                    if (ia_reg == AW'(AREAS - 1)) begin
                        ia_next = '0;
                        if (ir_reg == RW'(ROWS - 1)) begin
                            iss_done_next = 1'b1;
                            ir_next       = '0;
                        end else begin
                            ir_next = ir_reg + 1'b1;
                        end
                    end else begin
                        ia_next = ia_reg + 1'b1;
                    end
                end else begin
                    d_vld_next = 1'b0;
                end
                if (d_vld_reg) begin
                    row_sum = tag_ok[d_area_reg] ? sum_reg + SUMW'(mem_rdata) : sum_reg;
                    if (d_area_reg == AW'(AREAS - 1)) begin
                        best_cand = (row_sum < best_reg) ? row_sum : best_reg;
                        best_next = best_cand;
                        sum_next  = '0;
                        if (d_last_reg) begin
                            res_next   = wcus_pkg::CNT_W'(best_cand);
                            state_next = ST_DONE;
                        end
                    end else begin
                        sum_next = row_sum;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_reg;
                    state_next   = ST_IDLE;
                    if (mode_reg == wcus_pkg::MODE_INSERT) begin
                        count_next = count_inc;
                        if (&count_reg) begin
                            epoch_next = '0;
                            rem_next   = '0;
                            area_next  = '0;
                        end else if (rem_reg + 1'b1 == w_eff) begin
                            rem_next   = '0;
                            epoch_next = epoch_reg + 1'b1;
                            if ((&epoch_reg[wcus_pkg::TAG_W-1:0])
                                    || (area_reg == AW'(AREAS - 1))) begin
                                area_next = '0;
                            end else begin
                                area_next = area_reg + 1'b1;
                            end
                        end else begin
                            rem_next = rem_reg + 1'b1;
                        end
                    end else if (mode_reg == wcus_pkg::MODE_CLEAR) begin
                        count_next = '0;
                        epoch_next = '0;
                        rem_next   = '0;
                        area_next  = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            window_next = cfg_wr_data;
            pend_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            window_reg    <= wcus_pkg::WIN_RESET;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            epoch_reg     <= '0;
            rem_reg       <= '0;
            area_reg      <= '0;
            init_addr_reg <= '0;
            iss_done_reg  <= 1'b0;
            d_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int a = 0; a < AREAS; a++) begin
                tag_reg[a] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            rem_reg       <= rem_next;
            area_reg      <= area_next;
            init_addr_reg <= init_addr_next;
            iss_done_reg  <= iss_done_next;
            d_vld_reg     <= d_vld_next;
            m_valid_reg   <= m_valid_next;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        col_reg     <= col_next;
        lb_reg      <= lb_next;
        ir_reg      <= ir_next;
        ia_reg      <= ia_next;
        clr_col_reg <= clr_col_next;
        d_row_reg   <= d_row_next;
        d_area_reg  <= d_area_next;
        d_last_reg  <= d_last_next;
        cell_reg    <= cell_next;
        min_reg     <= min_next;
        sum_reg     <= sum_next;
        best_reg    <= best_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
    end

    // read and write phases never overlap on the counter memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("counter memory read and write in the same cycle");

    // the running remainder stays below the window while items are taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !pend_reg) |-> ({1'b0, rem_reg} < {1'b0, w_eff}))
        else $error("epoch remainder out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        area_reg <= AW'(AREAS - 1))
        else $error("area index out of range");

    // a result only appears from the completion state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result item raised outside completion");

endmodule

// ===== src/wcus_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wcus_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  wcus_pkg::div_req_t  req,
    output wcus_pkg::div_rsp_t  rsp
);

    localparam int STEP_W = $clog2(wcus_pkg::CNT_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            cnt_reg, cnt_next;
    logic [wcus_pkg::CNT_W-1:0]   quo_reg, quo_next;
    logic [wcus_pkg::WIN_W-1:0]   rem_reg, rem_next;
    logic [wcus_pkg::WIN_W-1:0]   dvs_reg, dvs_next;
    logic [wcus_pkg::WIN_W:0]     trial;
    logic [wcus_pkg::WIN_W:0]     diff;
    logic                         fits;

    always_comb begin
        trial = {rem_reg, quo_reg[wcus_pkg::CNT_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[wcus_pkg::CNT_W-2:0], fits};
            rem_next = fits ? diff[wcus_pkg::WIN_W-1:0] : trial[wcus_pkg::WIN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(wcus_pkg::CNT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== src/wcus_mem.sv =====
// counter memory, one write port and one registered read port
`timescale 1ns / 1ps

module wcus_mem #(
    parameter int ADDR_W = 14
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [wcus_pkg::CELL_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [wcus_pkg::CELL_W-1:0] rdata
);

    logic [wcus_pkg::CELL_W-1:0] mem [2**ADDR_W];
    logic [wcus_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
